// ----- hw/rtl/dcmsel_pkg.sv -----
// ----------------------------------------------------------------------------
// dcmsel_pkg
// Shared types and constants for the boost DCM/CCM duty selection block.
// ----------------------------------------------------------------------------
package dcmsel_pkg;

    // Channel count default
    localparam int CHANNELS_DEF = 2;

    // Field widths
    localparam int CH_W    = 3;
    localparam int CMP_W   = 16;
    localparam int REF_W   = 32;
    localparam int VIN_W   = 16;
    localparam int GAIN_W  = 31;
    localparam int QUOT_W  = 31;
    localparam int DIV_W   = 16;
    localparam int PROD_W  = QUOT_W + DIV_W;
    localparam int ROOT_W  = 16;
    localparam int STEP_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Hysteresis and scale constants
    localparam logic [CMP_W-1:0] ENTER_DELTA = 16'd8000;
    localparam logic [CMP_W-1:0] EXIT_DELTA  = 16'd5000;
    localparam logic [DIV_W-1:0] GAIN_SCALE  = 16'd10000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DCM_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_DELAY = 2'd3;

    // Operation codes
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Register reset values
    localparam logic [GAIN_W-1:0] DCM_GAIN_RST    = '0;
    localparam logic [CMP_W-1:0]  COMPARE_MAX_RST = 16'd65535;
    localparam logic [CMP_W-1:0]  COMPARE_MIN_RST = 16'd0;
    localparam logic [CMP_W-1:0]  ENTER_DELAY_RST = 16'd10000;

    typedef struct packed {
        logic                    op;
        logic [CH_W-1:0]         channel;
        logic [CMP_W-1:0]        ccm_compare;
        logic signed [REF_W-1:0] current_ref;
        logic [VIN_W-1:0]        input_voltage;
    } t_in;

    typedef struct packed {
        logic [CMP_W-1:0] compare_out;
        logic             freewheel_enable;
        logic [CMP_W-1:0] dcm_duty;
    } t_out;

    // Channel state update result
    typedef struct packed {
        logic [CMP_W-1:0] compare_out;
        logic             ccm_mode;
    } t_chan_res;

    // Channel update request
    typedef struct packed {
        logic             commit;
        logic             clear;
        logic [CH_W-1:0]  channel;
        logic [CMP_W-1:0] ccm_compare;
        logic [CMP_W-1:0] dcm_duty;
    } t_chan_req;

endpackage

// ----- hw/rtl/dcmsel_muldiv.sv -----
// ----------------------------------------------------------------------------
// dcmsel_muldiv
// Saturating multiply-divide: floor(a*b/d) limited to 2^31-1, a registered
// product followed by a restoring divider that retires one quotient bit a cycle.
// ----------------------------------------------------------------------------
module dcmsel_muldiv (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [dcmsel_pkg::QUOT_W-1:0]    i_a,
    input  logic [dcmsel_pkg::DIV_W-1:0]     i_b,
    input  logic [dcmsel_pkg::DIV_W-1:0]     i_d,
    output logic                             o_done,
    output logic [dcmsel_pkg::QUOT_W-1:0]    o_q
);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_MUL  = 3'd1;
    localparam logic [2:0] P_CHK  = 3'd2;
    localparam logic [2:0] P_DIV  = 3'd3;
    localparam logic [2:0] P_FIN  = 3'd4;

    localparam logic [dcmsel_pkg::STEP_W-1:0] LAST_STEP =
        dcmsel_pkg::STEP_W'(dcmsel_pkg::QUOT_W - 1);

    logic [2:0]                         r_phase;
    logic [dcmsel_pkg::STEP_W-1:0]      r_cnt;
    logic [dcmsel_pkg::QUOT_W-1:0]      r_a;
    logic [dcmsel_pkg::DIV_W-1:0]       r_b;
    logic [dcmsel_pkg::DIV_W-1:0]       r_d;
    logic [dcmsel_pkg::PROD_W-1:0]      r_prod;
    logic [dcmsel_pkg::DIV_W-1:0]       r_rem;
    logic [dcmsel_pkg::QUOT_W-1:0]      r_lo;

    logic [dcmsel_pkg::DIV_W:0]         trial;
    logic [dcmsel_pkg::DIV_W:0]         diff;
    logic                               ge;
    logic [dcmsel_pkg::DIV_W-1:0]       prod_hi;

    // Shared subtract-compare of one divider step
    assign trial   = {r_rem, r_lo[dcmsel_pkg::QUOT_W-1]};
    assign ge      = trial >= {1'b0, r_d};
    assign diff    = trial - {1'b0, r_d};
    assign prod_hi = r_prod[dcmsel_pkg::PROD_W-1:dcmsel_pkg::QUOT_W];

    assign o_done = (r_phase == P_FIN);
    assign o_q    = r_lo;

    // Sequence product, overflow check and divide steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_phase <= P_MUL;
                    end
                end
                P_MUL: begin
                    r_phase <= P_CHK;
                end
                P_CHK: begin
                    r_cnt   <= '0;
                    r_phase <= (prod_hi >= r_d) ? P_FIN : P_DIV;
                end
                P_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_phase <= P_FIN;
                    end
                end
                P_FIN: begin
                    r_phase <= P_IDLE;
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    // Datapath: operands, product, remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (r_phase == P_IDLE && i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_d <= i_d;
        end
        if (r_phase == P_MUL) begin
            r_prod <= dcmsel_pkg::PROD_W'(r_a) * dcmsel_pkg::PROD_W'(r_b);
        end
        if (r_phase == P_CHK) begin
            if (prod_hi >= r_d) begin
                r_lo <= '1;
            end else begin
                r_rem <= prod_hi;
                r_lo  <= r_prod[dcmsel_pkg::QUOT_W-1:0];
            end
        end
        if (r_phase == P_DIV) begin
            r_rem <= ge ? diff[dcmsel_pkg::DIV_W-1:0] : trial[dcmsel_pkg::DIV_W-1:0];
            r_lo  <= {r_lo[dcmsel_pkg::QUOT_W-2:0], ge};
        end
    end

endmodule

// ----- hw/rtl/dcmsel_isqrt.sv -----
// ----------------------------------------------------------------------------
// dcmsel_isqrt
// Exact floor square root of a 31-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module dcmsel_isqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [dcmsel_pkg::QUOT_W-1:0]    i_v,
    output logic                             o_done,
    output logic [dcmsel_pkg::ROOT_W-1:0]    o_root
);

    localparam int RAD_W = 2 * dcmsel_pkg::ROOT_W;
    localparam int REM_W = dcmsel_pkg::ROOT_W + 2;
    localparam int TRY_W = REM_W + 2;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_RUN  = 2'd1;
    localparam logic [1:0] P_FIN  = 2'd2;

    localparam logic [dcmsel_pkg::STEP_W-1:0] LAST_STEP =
        dcmsel_pkg::STEP_W'(dcmsel_pkg::ROOT_W - 1);

    logic [1:0]                         r_phase;
    logic [dcmsel_pkg::STEP_W-1:0]      r_cnt;
    logic [RAD_W-1:0]                   r_v;
    logic [REM_W-1:0]                   r_rem;
    logic [dcmsel_pkg::ROOT_W-1:0]      r_root;

    logic [TRY_W-1:0]                   acc;
    logic [TRY_W-1:0]                   test;
    logic                               ge;

    // Bring down two radicand bits and try root*4+1
    assign acc  = {r_rem, r_v[RAD_W-1:RAD_W-2]};
    assign test = TRY_W'({r_root, 2'b01});
    assign ge   = acc >= test;

    assign o_done = (r_phase == P_FIN);
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_phase)
                P_IDLE: begin
                    r_cnt <= '0;
                    if (i_start) begin
                        r_phase <= P_RUN;
                    end
                end
                P_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_phase <= P_FIN;
                    end
                end
                P_FIN: begin
                    r_phase <= P_IDLE;
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    // Load radicand, then advance one root bit a cycle
    always_ff @(posedge i_clk) begin
        if (r_phase == P_IDLE && i_start) begin
            r_v    <= RAD_W'(i_v);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_phase == P_RUN) begin
            r_v    <= {r_v[RAD_W-3:0], 2'b00};
            r_rem  <= ge ? REM_W'(acc - test) : REM_W'(acc);
            r_root <= {r_root[dcmsel_pkg::ROOT_W-2:0], ge};
        end
    end

endmodule

// ----- hw/rtl/dcmsel_chan.sv -----
// ----------------------------------------------------------------------------
// dcmsel_chan
// Per-channel DCM entry counter and mode flag with hysteresis selection.
// ----------------------------------------------------------------------------
module dcmsel_chan #(
    parameter int CHANNELS = dcmsel_pkg::CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dcmsel_pkg::t_chan_req          i_req,
    input  logic [dcmsel_pkg::CMP_W-1:0]   i_compare_max,
    input  logic [dcmsel_pkg::CMP_W-1:0]   i_enter_delay,
    output dcmsel_pkg::t_chan_res          o_res
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                           r_ccm_mode    [CHANNELS];
    logic [dcmsel_pkg::CMP_W-1:0]   r_enter_count [CHANNELS];

    logic [IDX_W-1:0]               idx;
    logic [dcmsel_pkg::CMP_W-1:0]   th_enter;
    logic [dcmsel_pkg::CMP_W-1:0]   th_exit;
    logic [dcmsel_pkg::CMP_W-1:0]   cnt;
    logic [dcmsel_pkg::CMP_W-1:0]   n_cnt;
    logic                           n_mode;
    logic [dcmsel_pkg::CMP_W-1:0]   dcm_cmp;

    assign idx = i_req.channel[IDX_W-1:0];
    assign cnt = r_enter_count[idx];

    // Thresholds floored at zero
    assign th_enter = (i_req.ccm_compare > dcmsel_pkg::ENTER_DELTA) ?
                      i_req.ccm_compare - dcmsel_pkg::ENTER_DELTA : '0;
    assign th_exit  = (i_req.ccm_compare > dcmsel_pkg::EXIT_DELTA) ?
                      i_req.ccm_compare - dcmsel_pkg::EXIT_DELTA : '0;

    // Next counter and mode for the addressed channel
    always_comb begin
        n_cnt  = cnt;
        n_mode = r_ccm_mode[idx];
        if (i_req.dcm_duty < th_enter) begin
            if (cnt < i_enter_delay) begin
                n_cnt = cnt + 1'b1;
            end
            if (n_cnt >= i_enter_delay) begin
                n_mode = 1'b0;
            end
        end else if (i_req.dcm_duty > th_exit) begin
            n_mode = 1'b1;
            n_cnt  = '0;
        end else if (r_ccm_mode[idx]) begin
            n_cnt = '0;
        end
    end

    // Compare code in DCM saturates at zero
    assign dcm_cmp = (i_compare_max >= i_req.dcm_duty) ?
                     i_compare_max - i_req.dcm_duty : '0;

    assign o_res.ccm_mode    = n_mode;
    assign o_res.compare_out = n_mode ? i_req.ccm_compare : dcm_cmp;

    // Hold channel state; clear all or commit one
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CHANNELS; i++) begin
            if (!i_rst_n || i_req.clear) begin
                r_ccm_mode[i]    <= 1'b1;
                r_enter_count[i] <= '0;
            end else if (i_req.commit && idx == IDX_W'(i)) begin
                r_ccm_mode[i]    <= n_mode;
                r_enter_count[i] <= n_cnt;
            end
        end
    end

endmodule

// ----- hw/rtl/boost_dcm_ccm_duty_select.sv -----
// ----------------------------------------------------------------------------
// boost_dcm_ccm_duty_select
// Boost converter duty selection between discontinuous and continuous
// conduction per phase channel, with a shared multiply-divide unit and an
// iterative square root.
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------
//   in      | i_in_valid / o_in_ready  | i_in  (op, channel, compare, ref, vin)
//   out     | o_out_valid / i_out_ready| o_out (compare, freewheel, dcm duty)
//   cfg     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// With the DCM math active, a step item runs the shared multiply-divide unit
// twice (a product, an overflow check and, unless it saturates, 31 divide
// steps each) around a 16-step square root. Items that fall back to the CCM
// duty go to clamp and output. The input side accepts a new item once the
// previous result sits in the output register. Reset is synchronous and
// returns every channel to CCM with its counter at zero.
// ----------------------------------------------------------------------------
module boost_dcm_ccm_duty_select #(
    parameter int CHANNELS = dcmsel_pkg::CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dcmsel_pkg::t_in                     i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dcmsel_pkg::t_out                    o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dcmsel_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dcmsel_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MD1  = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_MD2  = 3'd3;
    localparam logic [2:0] S_CLMP = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam int RAW_W = dcmsel_pkg::REF_W;

    // Configuration registers
    logic [dcmsel_pkg::GAIN_W-1:0]  r_dcm_gain;
    logic [dcmsel_pkg::CMP_W-1:0]   r_compare_max;
    logic [dcmsel_pkg::CMP_W-1:0]   r_compare_min;
    logic [dcmsel_pkg::CMP_W-1:0]   r_enter_delay;

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    logic [dcmsel_pkg::CH_W-1:0]    r_channel;
    logic [dcmsel_pkg::CMP_W-1:0]   r_ccm;
    logic signed [RAW_W-1:0]        r_raw;
    logic [dcmsel_pkg::CMP_W-1:0]   r_dcm;
    logic                           r_out_valid;
    dcmsel_pkg::t_out               r_out;

    logic                           in_xfer;
    logic                           is_step;
    logic signed [dcmsel_pkg::CMP_W:0] duty;
    logic                           fallback;
    logic                           out_free;
    logic                           md_start;
    logic [dcmsel_pkg::QUOT_W-1:0]  md_a;
    logic [dcmsel_pkg::DIV_W-1:0]   md_b;
    logic [dcmsel_pkg::DIV_W-1:0]   md_d;
    logic                           md_done;
    logic [dcmsel_pkg::QUOT_W-1:0]  md_q;
    logic                           sq_done;
    logic [dcmsel_pkg::ROOT_W-1:0]  sq_root;
    logic [dcmsel_pkg::CMP_W-1:0]   clamped;
    dcmsel_pkg::t_chan_req          chan_req;
    dcmsel_pkg::t_chan_res          chan_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // A step item counts only for channels that exist
    assign is_step = (i_in.op == dcmsel_pkg::OP_STEP) &&
                     (32'(i_in.channel) < 32'(CHANNELS));

    // CCM duty and fallback decision on the incoming item
    assign duty = $signed({1'b0, r_compare_max}) - $signed({1'b0, i_in.ccm_compare});
    assign fallback = (r_dcm_gain == '0) || i_in.current_ref[dcmsel_pkg::REF_W-1] ||
                      (i_in.current_ref == '0) || (i_in.input_voltage == '0) ||
                      (duty <= 0);

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcm_gain    <= dcmsel_pkg::DCM_GAIN_RST;
            r_compare_max <= dcmsel_pkg::COMPARE_MAX_RST;
            r_compare_min <= dcmsel_pkg::COMPARE_MIN_RST;
            r_enter_delay <= dcmsel_pkg::ENTER_DELAY_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dcmsel_pkg::REG_DCM_GAIN: begin
                    r_dcm_gain <= i_cfg_data[dcmsel_pkg::GAIN_W-1:0];
                end
                dcmsel_pkg::REG_COMPARE_MAX: begin
                    r_compare_max <= i_cfg_data[dcmsel_pkg::CMP_W-1:0];
                end
                dcmsel_pkg::REG_COMPARE_MIN: begin
                    r_compare_min <= i_cfg_data[dcmsel_pkg::CMP_W-1:0];
                end
                dcmsel_pkg::REG_ENTER_DELAY: begin
                    r_enter_delay <= i_cfg_data[dcmsel_pkg::CMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Shared multiply-divide operands: ref*duty/vin, then gain*root/scale
    assign md_start = (r_state == S_IDLE) ? (in_xfer && is_step && !fallback) :
                      ((r_state == S_SQ) && sq_done);
    assign md_a = (r_state == S_IDLE) ? i_in.current_ref[dcmsel_pkg::QUOT_W-1:0] :
                                        r_dcm_gain;
    assign md_b = (r_state == S_IDLE) ? duty[dcmsel_pkg::DIV_W-1:0] : sq_root;
    assign md_d = (r_state == S_IDLE) ? i_in.input_voltage : dcmsel_pkg::GAIN_SCALE;

    dcmsel_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_a     (md_a),
        .i_b     (md_b),
        .i_d     (md_d),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    dcmsel_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_MD1) && md_done),
        .i_v     (md_q),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // Clamp: above max to max, else below min to min
    always_comb begin
        if (r_raw > $signed(RAW_W'(r_compare_max))) begin
            clamped = r_compare_max;
        end else if (r_raw < $signed(RAW_W'(r_compare_min))) begin
            clamped = r_compare_min;
        end else begin
            clamped = r_raw[dcmsel_pkg::CMP_W-1:0];
        end
    end

    assign chan_req.commit      = (r_state == S_OUT) && out_free;
    assign chan_req.clear       = in_xfer && (i_in.op == dcmsel_pkg::OP_CLEAR);
    assign chan_req.channel     = r_channel;
    assign chan_req.ccm_compare = r_ccm;
    assign chan_req.dcm_duty    = r_dcm;

    dcmsel_chan #(
        .CHANNELS (CHANNELS)
    ) u_chan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (chan_req),
        .i_compare_max (r_compare_max),
        .i_enter_delay (r_enter_delay),
        .o_res         (chan_res)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && is_step) begin
                    n_state = fallback ? S_CLMP : S_MD1;
                end
            end
            S_MD1: begin
                if (md_done) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (sq_done) begin
                    n_state = S_MD2;
                end
            end
            S_MD2: begin
                if (md_done) begin
                    n_state = S_CLMP;
                end
            end
            S_CLMP: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (chan_req.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload, raw duty and output register
    always_ff @(posedge i_clk) begin
        if (in_xfer && is_step) begin
            r_channel <= i_in.channel;
            r_ccm     <= i_in.ccm_compare;
            r_raw     <= RAW_W'(duty);
        end
        if (r_state == S_MD2 && md_done) begin
            r_raw <= RAW_W'(md_q);
        end
        if (r_state == S_CLMP) begin
            r_dcm <= clamped;
        end
        if (chan_req.commit) begin
            r_out.compare_out      <= chan_res.compare_out;
            r_out.freewheel_enable <= chan_res.ccm_mode;
            r_out.dcm_duty         <= r_dcm;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
